// ----- rtl/ngenv_pkg.sv -----
// Package: shared types, register indexes and reset values for the noise gate envelope.
`default_nettype none

package ngenv_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_HOLD_TIME = 2'd1;
	localparam logic [1:0] REG_ATTACK    = 2'd2;
	localparam logic [1:0] REG_RELEASE   = 2'd3;

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 20;
	localparam int LEVEL_BITS    = 16;
	localparam int HOLD_BITS     = 20;
	localparam int COEF_BITS     = 16;

	// Register reset values
	localparam logic [15:0] THRESHOLD_RST = 16'd0;
	localparam logic [19:0] HOLD_TIME_RST = 20'd0;
	localparam logic [15:0] ATTACK_RST    = 16'd6554;
	localparam logic [15:0] RELEASE_RST   = 16'd64881;

	// Register file contents handed to the sequencer
	typedef struct packed {
		logic signed [LEVEL_BITS-1:0] gate_thr;
		logic [HOLD_BITS-1:0]         hold_time;
		logic [COEF_BITS-1:0]         attack_coef;
		logic [COEF_BITS-1:0]         release_coef;
	} cfg_t;

endpackage

`default_nettype wire

// ----- rtl/noise_gate_envelope_top.sv -----
// Top level of the noise gate envelope (attack, hold, release).
//
// One audio sample and its level reading in, one gated sample and the gain
// out. Every gain update and every sample scaling runs on a single shared
// multiplier with a registered product, stepped by a small sequencer. When
// the gain does not change, an item uses no multiplier pass; each gain phase
// that scales the gain (attack, release, or both) makes two multiplier
// passes (gain update, then sample scaling). The block is ready again in
// the cycle the result appears. The block accepts no item while one is in
// work, but takes the next item while a result still waits in the output
// register; that item then stalls before its result until the waiting one is
// taken. Configuration writes are taken at any time and must only be issued
// while the block is idle.
`default_nettype none

module noise_gate_envelope_top
	import ngenv_pkg::*;
#(
	parameter int SAMPLE_BITS    = 16,
	parameter int GAIN_FRAC_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]        cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]       cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0]  sample_in,
	input  wire logic signed [LEVEL_BITS-1:0]   level_db,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [SAMPLE_BITS-1:0]       sample_out,
	output logic [GAIN_FRAC_BITS+1:0]           gain_now
);

	localparam int GB     = GAIN_FRAC_BITS + 2;
	localparam int A_BITS = ((SAMPLE_BITS > GB) ? SAMPLE_BITS : GB) + 1;
	localparam int B_BITS = ((GB > COEF_BITS + 1) ? GB : COEF_BITS + 1) + 1;

	cfg_t                            cfg;
	logic signed [A_BITS-1:0]        mul_a;
	logic signed [B_BITS-1:0]        mul_b;
	logic signed [A_BITS+B_BITS-1:0] mul_p;

	// Register file
	ngenv_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Shared multiplier
	ngenv_mul #(
		.A_BITS (A_BITS),
		.B_BITS (B_BITS)
	) u_mul (
		.clk   (clk),
		.mul_a (mul_a),
		.mul_b (mul_b),
		.mul_p (mul_p)
	);

	// Sequencer
	ngenv_seq #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS),
		.A_BITS         (A_BITS),
		.B_BITS         (B_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.level_db   (level_db),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.gain_now   (gain_now),
		.mul_a      (mul_a),
		.mul_b      (mul_b),
		.mul_p      (mul_p)
	);

endmodule

`default_nettype wire

// ----- rtl/ngenv_cfg.sv -----
// Configuration register file for the noise gate envelope.
`default_nettype none

module ngenv_cfg
	import ngenv_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
	output cfg_t                          cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register writes, upper data bits dropped per register width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gate_thr     <= THRESHOLD_RST;
			cfg_q.hold_time    <= HOLD_TIME_RST;
			cfg_q.attack_coef  <= ATTACK_RST;
			cfg_q.release_coef <= RELEASE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_THRESHOLD: cfg_q.gate_thr     <= cfg_data[LEVEL_BITS-1:0];
				REG_HOLD_TIME: cfg_q.hold_time    <= cfg_data[HOLD_BITS-1:0];
				REG_ATTACK:    cfg_q.attack_coef  <= cfg_data[COEF_BITS-1:0];
				REG_RELEASE:   cfg_q.release_coef <= cfg_data[COEF_BITS-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ngenv_mul.sv -----
// Shared signed multiplier with a registered product.
`default_nettype none

module ngenv_mul #(
	parameter int A_BITS = 19,
	parameter int B_BITS = 19
) (
	input  wire logic                            clk,
	input  wire logic signed [A_BITS-1:0]        mul_a,
	input  wire logic signed [B_BITS-1:0]        mul_b,
	output logic signed [A_BITS+B_BITS-1:0]      mul_p
);

	logic signed [A_BITS+B_BITS-1:0] prod_q;

	// One product per cycle, result available the next cycle
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	assign mul_p = prod_q;

endmodule

`default_nettype wire

// ----- rtl/ngenv_seq.sv -----
// Sequencer: gate state, step rules and output register around the shared multiplier.
`default_nettype none

module ngenv_seq
	import ngenv_pkg::*;
#(
	parameter int SAMPLE_BITS    = 16,
	parameter int GAIN_FRAC_BITS = 16,
	parameter int A_BITS         = 19,
	parameter int B_BITS         = 19
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire cfg_t                            cfg,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0]   sample_in,
	input  wire logic signed [LEVEL_BITS-1:0]    level_db,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic signed [SAMPLE_BITS-1:0]        sample_out,
	output logic [GAIN_FRAC_BITS+1:0]            gain_now,
	output logic signed [A_BITS-1:0]             mul_a,
	output logic signed [B_BITS-1:0]             mul_b,
	input  wire logic signed [A_BITS+B_BITS-1:0] mul_p
);

	localparam int GB = GAIN_FRAC_BITS + 2;
	localparam int SB = SAMPLE_BITS;
	localparam int PW = A_BITS + B_BITS;
	localparam int RW = PW - GAIN_FRAC_BITS;
	localparam logic [GB-1:0] GAIN_SEED =
		GB'(((64'd1 << GAIN_FRAC_BITS) + 64'd50) / 64'd100);

	// Sequencer states
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ATK   = 4'd1;
	localparam logic [3:0] ST_ATK_G = 4'd2;
	localparam logic [3:0] ST_ATK_S = 4'd3;
	localparam logic [3:0] ST_ATK_W = 4'd4;
	localparam logic [3:0] ST_HOLD  = 4'd5;
	localparam logic [3:0] ST_REL   = 4'd6;
	localparam logic [3:0] ST_REL_G = 4'd7;
	localparam logic [3:0] ST_REL_S = 4'd8;
	localparam logic [3:0] ST_REL_W = 4'd9;
	localparam logic [3:0] ST_FIN   = 4'd10;

	logic [3:0]              state_q;
	logic [GB-1:0]           gain_q;
	logic                    atk_q;
	logic                    hold_q;
	logic                    rel_q;
	logic [HOLD_BITS-1:0]    cnt_q;
	logic signed [SB-1:0]    last_q;
	logic signed [SB-1:0]    sample_q;
	logic                    out_valid_q;
	logic signed [SB-1:0]    sample_out_q;
	logic [GB-1:0]           gain_now_q;

	logic                    accept;
	logic                    gain_ge_one;
	logic                    gain_lt_one;
	logic signed [RW-1:0]    shr;
	logic signed [SB-1:0]    sat;
	logic [GB-1:0]           prod_gain;
	logic                    hold_f;
	logic                    rel_f;
	logic [HOLD_BITS-1:0]    cnt_f;
	logic                    cnt_run;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign gain_now   = gain_now_q;

	assign gain_ge_one = |gain_q[GB-1:GAIN_FRAC_BITS];
	assign gain_lt_one = !gain_ge_one;

	// Product scaled back to gain format (coefficients carry 16 fraction bits)
	assign prod_gain = mul_p[GB+COEF_BITS-1:COEF_BITS];

	// Sample times gain: floor shift, then saturate to sample width
	assign shr = mul_p[PW-1:GAIN_FRAC_BITS];
	always_comb begin
		if ((&shr[RW-1:SB-1]) || !(|shr[RW-1:SB-1])) begin
			sat = shr[SB-1:0];
		end else if (shr[RW-1]) begin
			sat = {1'b1, {(SB-1){1'b0}}};
		end else begin
			sat = {1'b0, {(SB-1){1'b1}}};
		end
	end

	// Hold phase rules: unity reached, pass-through count, release entry
	always_comb begin
		hold_f  = hold_q || gain_ge_one;
		cnt_run = hold_f && (cnt_q < cfg.hold_time);
		cnt_f   = cnt_run ? cnt_q + 1'b1 : cnt_q;
		rel_f   = rel_q;
		if (cnt_f == cfg.hold_time) begin
			hold_f = 1'b0;
			rel_f  = 1'b1;
		end
	end

	// Multiplier operand selection
	always_comb begin
		case (state_q)
			ST_ATK: begin
				mul_a = $signed({{(A_BITS-GB){1'b0}}, gain_q});
				mul_b = $signed({{(B_BITS-COEF_BITS-1){1'b0}}, 1'b1, cfg.attack_coef});
			end
			ST_ATK_S, ST_REL_S: begin
				mul_a = $signed({{(A_BITS-SB){sample_q[SB-1]}}, sample_q});
				mul_b = $signed({{(B_BITS-GB){1'b0}}, gain_q});
			end
			default: begin
				mul_a = $signed({{(A_BITS-GB){1'b0}}, gain_q});
				mul_b = $signed({{(B_BITS-COEF_BITS){1'b0}}, cfg.release_coef});
			end
		endcase
	end

	// Sample capture
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample_in;
		end
	end

	// Sequencer and gate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gain_q      <= '0;
			atk_q       <= 1'b0;
			hold_q      <= 1'b0;
			rel_q       <= 1'b0;
			cnt_q       <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// Level over threshold opens the gate
						if ((level_db > cfg.gate_thr) && !atk_q) begin
							cnt_q <= '0;
							rel_q <= 1'b0;
							atk_q <= 1'b1;
							if (gain_q == '0) begin
								gain_q <= GAIN_SEED;
							end
						end
						state_q <= ST_ATK;
					end
				end
				ST_ATK: begin
					state_q <= (atk_q && gain_lt_one) ? ST_ATK_G : ST_HOLD;
				end
				ST_ATK_G: begin
					gain_q  <= prod_gain;
					state_q <= ST_ATK_S;
				end
				ST_ATK_S: begin
					state_q <= ST_ATK_W;
				end
				ST_ATK_W: begin
					last_q  <= sat;
					state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (gain_ge_one) begin
						atk_q <= 1'b0;
					end
					if (cnt_run) begin
						last_q <= sample_q;
					end
					hold_q  <= hold_f;
					rel_q   <= rel_f;
					cnt_q   <= cnt_f;
					state_q <= ST_REL;
				end
				ST_REL: begin
					state_q <= (rel_q && (gain_q != '0)) ? ST_REL_G : ST_FIN;
				end
				ST_REL_G: begin
					gain_q  <= prod_gain;
					state_q <= ST_REL_S;
				end
				ST_REL_S: begin
					state_q <= ST_REL_W;
				end
				ST_REL_W: begin
					last_q  <= sat;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					// Load the output register once the previous item is gone
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && (!out_valid_q || out_ready)) begin
			sample_out_q <= last_q;
			gain_now_q   <= gain_q;
		end
	end

endmodule

`default_nettype wire
